>>> rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared widths and command/status types for the cosine similarity engine
// ----------------------------------------------------------------------------
package cse_pkg;
  localparam int unsigned ELEM_BITS = 16;
  localparam int unsigned MAX_LEN   = 1024;
  localparam int unsigned DOT_W     = 42;
  localparam int unsigned NORM_W    = 41;
  localparam int unsigned ROOT_W    = 21;
  localparam int unsigned DEN_W     = 42;
  localparam int unsigned NUM_W     = 57;  // 42-bit magnitude shifted by 15
  localparam int unsigned QUO_W     = 17;  // enough to see saturation
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned OUT_FRAC  = 15;

  typedef struct packed {
    logic acc;        // accumulate one element pair
    logic clear;      // clear the sums after the capture
    logic sqrt_start; // load the root iterators
    logic sqrt_step;  // one root iteration
    logic mul_den;    // form the denominator
    logic div_start;  // load the divider
    logic div_step;   // one divider iteration
    logic finish;     // register the result
  } cse_cmd_t;

  typedef struct packed {
    logic zero_norm;
  } cse_sts_t;
endpackage

>>> rtl/cse_stream_if.sv
// ----------------------------------------------------------------------------
// cse_stream_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface cse_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// accumulators, bit-serial square roots, denominator multiply and divider
// ----------------------------------------------------------------------------
module cse_datapath import cse_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cse_cmd_t                    cmd_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  output cse_sts_t                    sts_o,
  output logic signed [15:0]          sim_o,
  output logic                        zero_norm_o,
  output logic                        too_long_o
);
  logic [DOT_W-1:0]  dot_q, dot_d;
  logic [NORM_W-1:0] na_q, na_d, nb_q, nb_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [2*ELEM_BITS-1:0] pab, paa, pbb;

  assign pab = a_i * b_i;
  assign paa = a_i * a_i;
  assign pbb = b_i * b_i;

  always_comb begin
    dot_d = dot_q; na_d = na_q; nb_d = nb_q; cnt_d = cnt_q;
    if (cmd_i.acc) begin
      dot_d = dot_q + DOT_W'(pab);
      na_d  = na_q + NORM_W'(unsigned'(paa));
      nb_d  = nb_q + NORM_W'(unsigned'(pbb));
      if (cnt_q <= CNT_W'(MAX_LEN)) cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.clear) begin
      dot_d = '0; na_d = '0; nb_d = '0; cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; cnt_q <= '0;
    end else begin
      dot_q <= dot_d; na_q <= na_d; nb_q <= nb_d; cnt_q <= cnt_d;
    end
  end

  assign sts_o.zero_norm = (na_q == '0) || (nb_q == '0);

  // captured vector summary, magnitude may reach 2^41
  logic [DOT_W-1:0]  mag_q;
  logic              neg_q, zn_q, tl_q;
  // root iterators: remainder, root and bit, one bit pair a cycle
  logic [NORM_W:0]   ra_q, rb_q, resa_q, resb_q, bit_q;

  function automatic logic [2*(NORM_W+1)-1:0] sq_step(logic [NORM_W:0] n,
                                                      logic [NORM_W:0] res,
                                                      logic [NORM_W:0] bt);
    logic [NORM_W:0] t;
    t = res + bt;
    if (n >= t) return {n - t, (res >> 1) + bt};
    return {n, res >> 1};
  endfunction

  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] rem_q;
  logic [NUM_W-1:0] num_q;
  logic [QUO_W-1:0] quo_sat;
  logic [NUM_W:0]   trial;

  assign trial = {rem_q, num_q[NUM_W-1]} - {{(NUM_W+1-DEN_W){1'b0}}, den_q};

  logic [NUM_W-1:0] quo_full_q;
  logic signed [15:0] sim_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      neg_q  <= dot_q[DOT_W-1];
      mag_q  <= dot_q[DOT_W-1] ? -dot_q : dot_q;
      zn_q   <= sts_o.zero_norm;
      tl_q   <= cnt_q > CNT_W'(MAX_LEN);
      ra_q   <= {1'b0, na_q};
      rb_q   <= {1'b0, nb_q};
      resa_q <= '0;
      resb_q <= '0;
      bit_q  <= (NORM_W+1)'(1) << (NORM_W-1);
    end
    if (cmd_i.sqrt_step) begin
      {ra_q, resa_q} <= sq_step(ra_q, resa_q, bit_q);
      {rb_q, resb_q} <= sq_step(rb_q, resb_q, bit_q);
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mul_den) den_q <= resa_q[ROOT_W-1:0] * resb_q[ROOT_W-1:0];
    if (cmd_i.div_start) begin
      num_q      <= {mag_q, OUT_FRAC'(0)};
      rem_q      <= '0;
      quo_full_q <= '0;
    end
    if (cmd_i.div_step) begin
      // restoring division, one quotient bit a cycle
      num_q  <= num_q << 1;
      if (!trial[NUM_W]) begin
        rem_q      <= trial[NUM_W-1:0];
        quo_full_q <= {quo_full_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q      <= {rem_q[NUM_W-2:0], num_q[NUM_W-1]};
        quo_full_q <= {quo_full_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      if (zn_q) sim_q <= '0;
      else if (neg_q) sim_q <= (quo_sat > QUO_W'(32768)) ? -16'sd32768 : 16'(-quo_sat);
      else sim_q <= (quo_sat > QUO_W'(32767)) ? 16'sd32767 : 16'(quo_sat);
      zero_norm_o <= zn_q;
      too_long_o  <= tl_q;
    end
  end

  // saturate wide quotient into 17 bits
  assign quo_sat = (|quo_full_q[NUM_W-1:QUO_W]) ? {1'b1, {(QUO_W-1){1'b1}}}
                                                : quo_full_q[QUO_W-1:0];
  assign sim_o = sim_q;
endmodule

>>> rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// sequencer: accumulate, root, multiply, divide, deliver
// ----------------------------------------------------------------------------
module cse_ctrl import cse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cse_sts_t sts_i,
  output cse_cmd_t cmd_o
);
  typedef enum logic [2:0] {S_ACC, S_CAP, S_SQRT, S_MUL, S_DIVL, S_DIV, S_FIN, S_OUT} state_e;
  state_e    state_q;
  logic [5:0] cnt_q;
  logic       take;

  assign in_ready_o = (state_q == S_ACC);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.acc = take;
    unique case (state_q)
      S_CAP:  cmd_o.sqrt_start = 1'b1;
      S_SQRT: cmd_o.sqrt_step  = 1'b1;
      S_MUL:  begin cmd_o.mul_den = 1'b1; cmd_o.clear = 1'b1; end
      S_DIVL: cmd_o.div_start  = 1'b1;
      S_DIV:  cmd_o.div_step   = 1'b1;
      S_FIN:  cmd_o.finish     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC; cnt_q <= '0; out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_ACC:  if (take && in_last_i) state_q <= S_CAP;
        // sums stay intact until the clear in S_MUL, so the status holds till then
        S_CAP:  begin state_q <= sts_i.zero_norm ? S_MUL : S_SQRT; cnt_q <= '0; end
        S_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ROOT_W - 1)) state_q <= S_MUL;
        end
        S_MUL:  state_q <= sts_i.zero_norm ? S_FIN : S_DIVL;
        S_DIVL: begin state_q <= S_DIV; cnt_q <= '0; end
        S_DIV:  begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NUM_W - 1)) state_q <= S_FIN;
        end
        S_FIN:  begin state_q <= S_OUT; out_valid_o <= 1'b1; end
        S_OUT:  if (out_ready_i) begin out_valid_o <= 1'b0; state_q <= S_ACC; end
        default: state_q <= S_ACC;
      endcase
    end
  end
endmodule

>>> rtl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// streaming cosine similarity of two Q1.15 vectors
// ----------------------------------------------------------------------------
// Element pairs are taken one a cycle while a vector streams in. After the
// beat marked last the block stops taking input through one capture, the
// bit-serial square roots (both norms in parallel), one multiply, one
// divider load, the restoring division and one result register; it then
// holds the result beat until it is taken. A vector with a zero norm skips
// the roots and the divide, passing only the capture, multiply and result
// register states before its result beat.
module cosine_similarity_engine import cse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cse_stream_if.sink   in_if,
  cse_stream_if.source out_if
);
  cse_cmd_t cmd;
  cse_sts_t sts;

  cse_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.data.last),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cse_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .a_i        (in_if.data.a_value),
    .b_i        (in_if.data.b_value),
    .sts_o      (sts),
    .sim_o      (out_if.data.similarity),
    .zero_norm_o(out_if.data.zero_norm),
    .too_long_o (out_if.data.too_long)
  );
endmodule

>>> bench/cse_bench_types.sv
// ----------------------------------------------------------------------------
// cse_bench_types
// beat layouts for the input and output channels of the similarity engine
// ----------------------------------------------------------------------------
package cse_bench_types;
  import cse_pkg::*;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] a_value;
    logic signed [ELEM_BITS-1:0] b_value;
    logic                        last;
  } pair_beat_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
    logic               too_long;
  } sim_beat_t;
endpackage

>>> bench/cosine_similarity_engine_tb.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_tb
// streams element pairs into the engine and checks every similarity beat
// against a bit-true predictor of the sums, roots and saturating divide or a
// typed directed expectation, with bursty input and a stalling output side
// ----------------------------------------------------------------------------
module cosine_similarity_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cse_pkg::*;
  import cse_bench_types::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    pair_beat_t pair;
    bit         typed;
    sim_beat_t  want;
  } pair_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cse_stream_if #(.payload_t(pair_beat_t)) pair_if ();
  cse_stream_if #(.payload_t(sim_beat_t))  sim_if ();

  cosine_similarity_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pair_if.sink),
    .out_if (sim_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [DOT_W-1:0]  dot_acc;
  logic [NORM_W-1:0] norm_a_acc;
  logic [NORM_W-1:0] norm_b_acc;
  int unsigned       pairs_seen;
  sim_beat_t         sim_expected_q[$];
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left = 0;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 21; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // fold one pair into the sums; returns 1 with the result when last is set
  function automatic bit fold_pair(pair_beat_t p, output sim_beat_t r);
    logic signed [DOT_W-1:0] prod;
    logic [DOT_W-1:0]        mag;
    longint unsigned         den, q;
    bit                      neg;
    prod = DOT_W'(p.a_value * p.b_value);
    dot_acc    = dot_acc + prod;
    norm_a_acc = norm_a_acc + NORM_W'(p.a_value * p.a_value);
    norm_b_acc = norm_b_acc + NORM_W'(p.b_value * p.b_value);
    if (pairs_seen <= MAX_LEN) pairs_seen++;
    r = '0;
    if (!p.last) return 1'b0;
    r.too_long  = pairs_seen > MAX_LEN;
    r.zero_norm = (norm_a_acc == 0) || (norm_b_acc == 0);
    if (!r.zero_norm) begin
      den = floor_root(64'(norm_a_acc)) * floor_root(64'(norm_b_acc));
      neg = dot_acc[DOT_W-1];
      mag = neg ? -dot_acc : dot_acc;
      q = (64'(mag) << OUT_FRAC) / den;
      if (neg) begin
        if (q > 32768) q = 32768;
        r.similarity = 16'(-q);
      end else begin
        if (q > 32767) q = 32767;
        r.similarity = 16'(q);
      end
    end
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pairs_seen = 0;
    return 1'b1;
  endfunction

  task automatic send_pair(pair_beat_t p, bit typed, sim_beat_t want);
    sim_beat_t r;
    if (burst_left == 0) begin
      pair_if.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pair_if.valid = 1'b1;
    pair_if.data  = p;
    do @(posedge clk_i); while (!pair_if.ready);
    if (fold_pair(p, r)) sim_expected_q = {sim_expected_q, (typed ? want : r)};
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_elem(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 3) == 0 ? 0 : $urandom);
    endcase
  endfunction

  task automatic send_vector(int unsigned len);
    int unsigned style, shape;
    pair_beat_t  p;
    style = $urandom_range(0, 3);
    shape = $urandom_range(0, 4);
    for (int unsigned i = 0; i < len; i++) begin
      p.a_value = pick_elem(style);
      case (shape)
        0: p.b_value = p.a_value;
        1: p.b_value = -p.a_value;
        2: p.b_value = '0;
        default: p.b_value = pick_elem(style);
      endcase
      p.last = (i == len - 1);
      send_pair(p, 1'b0, '0);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    case ((cycle_count / 300) % 3)
      0: sim_if.ready <= 1'b1;
      1: sim_if.ready <= ($urandom_range(0, 3) != 0);
      default: sim_if.ready <= (cycle_count % 8) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    sim_beat_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cosine_similarity_engine verification failed");
      $finish;
    end
    if (rst_ni && sim_if.valid && sim_if.ready) begin
      if (sim_expected_q.size() == 0) begin
        $error("unexpected similarity beat %p", sim_if.data);
        fail_count++;
      end else begin
        want = sim_expected_q.pop_front();
        if (sim_if.data.similarity !== want.similarity) begin
          $error("similarity: expected %0d, got %0d", want.similarity,
                 sim_if.data.similarity);
          fail_count++;
        end
        if (sim_if.data.zero_norm !== want.zero_norm) begin
          $error("zero_norm: expected %0b, got %0b", want.zero_norm, sim_if.data.zero_norm);
          fail_count++;
        end
        if (sim_if.data.too_long !== want.too_long) begin
          $error("too_long: expected %0b, got %0b", want.too_long, sim_if.data.too_long);
          fail_count++;
        end
      end
    end
  end

  pair_row_t directed_rows[] = '{
    // single pairs at the extremes saturate to full scale
    '{'{16'sh7fff, 16'sh7fff, 1'b1}, 1'b1, '{16'sh7fff, 1'b0, 1'b0}},
    '{'{16'sh8000, 16'sh8000, 1'b1}, 1'b1, '{16'sh7fff, 1'b0, 1'b0}},
    '{'{16'sh8000, 16'sh7fff, 1'b1}, 1'b1, '{16'sh8000, 1'b0, 1'b0}},
    '{'{16'sh7fff, 16'sh8000, 1'b1}, 1'b1, '{16'sh8000, 1'b0, 1'b0}},
    // zero norm on either side
    '{'{16'sh0000, 16'sh0005, 1'b1}, 1'b1, '{16'sh0000, 1'b1, 1'b0}},
    '{'{16'sh1234, 16'sh0000, 1'b1}, 1'b1, '{16'sh0000, 1'b1, 1'b0}},
    '{'{16'sh0000, 16'sh0000, 1'b1}, 1'b1, '{16'sh0000, 1'b1, 1'b0}},
    // short vectors through the predictor
    '{'{16'sh0003, 16'sh0004, 1'b0}, 1'b0, '0},
    '{'{16'sh0004, -16'sd3,   1'b1}, 1'b0, '0},
    '{'{16'sh5555, -16'sd2,   1'b0}, 1'b0, '0},
    '{'{-16'sd1,   16'shaaaa, 1'b0}, 1'b0, '0},
    '{'{16'sh0001, 16'sh0001, 1'b1}, 1'b0, '0},
    '{'{16'sh0001, 16'sh0003, 1'b0}, 1'b0, '0},
    '{'{16'sh0002, 16'sh0000, 1'b1}, 1'b0, '0},
    '{'{16'sh7fff, 16'sh8000, 1'b0}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7fff, 1'b0}, 1'b0, '0},
    '{'{16'sh0100, 16'shff00, 1'b1}, 1'b0, '0}
  };

  initial begin
    pair_beat_t p;
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pairs_seen = 0;
    pair_if.valid = 1'b0;
    pair_if.data  = '0;
    sim_if.ready  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);

    // hold off until the pipeline has drained
    pair_if.valid = 1'b0;
    wait (sim_expected_q.size() == 0);
    @(negedge clk_i);

    // overlong vector, one pair past the length limit
    for (int unsigned i = 0; i < MAX_LEN + 1; i++) begin
      p.a_value = pick_elem(0);
      p.b_value = pick_elem(0);
      p.last = (i == MAX_LEN);
      send_pair(p, 1'b0, '0);
    end

    for (int unsigned n = 0; n < 110; n++)
      send_vector($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 12));

    pair_if.valid = 1'b0;
    wait (sim_expected_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0 && sim_expected_q.size() == 0) begin
      $display("cosine_similarity_engine verification clean");
    end else begin
      $display("cosine_similarity_engine verification failed");
    end
    $finish;
  end
endmodule

>>> cosine_similarity_engine.f
rtl/cse_pkg.sv
rtl/cse_stream_if.sv
rtl/cse_datapath.sv
rtl/cse_ctrl.sv
rtl/cosine_similarity_engine.sv
bench/cse_bench_types.sv
bench/cosine_similarity_engine_tb.sv
